/* rtl/kvtc_pkg.sv */
// Shared types and constants for the compacting key/value table.
`default_nettype none

package kvtc_pkg;

  localparam int KEY_W  = 64;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  // Per-cell strobes from the table controller.
  typedef struct packed {
    logic cmp;    // capture the key compare result
    logic load;   // store the new key and value
    logic shift;  // take the upper neighbor's entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/kvtc_cell.sv */
// One table cell: holds an entry, compares it and shifts it down on delete.
`default_nettype none

module kvtc_cell #(
  parameter int VALUE_BITS = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  kvtc_pkg::cell_ctrl_t        ctrl_i,
  input  wire                         valid_i,
  input  wire  [kvtc_pkg::KEY_W-1:0]  search_key_i,
  input  wire  [kvtc_pkg::KEY_W-1:0]  new_key_i,
  input  wire  [VALUE_BITS-1:0]       new_value_i,
  input  wire  [kvtc_pkg::KEY_W-1:0]  nbr_key_i,
  input  wire  [VALUE_BITS-1:0]       nbr_value_i,
  output logic [kvtc_pkg::KEY_W-1:0]  key_o,
  output logic [VALUE_BITS-1:0]       value_o,
  output logic                        match_o
);
  import kvtc_pkg::*;

  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q   <= new_key_i;
      value_q <= new_value_i;
    end else if (ctrl_i.shift) begin
      key_q   <= nbr_key_i;
      value_q <= nbr_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= valid_i && (key_q == search_key_i);
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

/* rtl/kvtc_match_enc.sv */
// Match encoder: turns the one-hot cell match vector into position and value.
`default_nettype none

module kvtc_match_enc #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire  [CAPACITY-1:0]                  match_i,
  input  wire  [CAPACITY-1:0][VALUE_BITS-1:0]  value_i,
  output logic                                 hit_o,
  output logic [$clog2(CAPACITY)-1:0]          pos_o,
  output logic [VALUE_BITS-1:0]                value_o
);
  import kvtc_pkg::*;

  localparam int POS_W = $clog2(CAPACITY);

  // Keys are unique in the table, so at most one match bit is set: OR together.
  always_comb begin
    pos_o   = '0;
    value_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_i[i]) begin
        pos_o   = pos_o | POS_W'(i);
        value_o = value_o | value_i[i];
      end
    end
  end

  assign hit_o = |match_i;

endmodule

`default_nettype wire

/* rtl/key_value_table_compacting.sv */
// Top level of the ordered, compacting key/value table built from a row of cells.
//
//  channel  | dir | tdata (low bit up)                                  | tuser
//  ---------+-----+-----------------------------------------------------+------
//  s_axis   | in  | key[63:0], value_in[VALUE_BITS-1:0], zero pad         | kind
//  m_axis   | out | found, position, value_out, entry_count, table_full,  | -
//           |     | zero pad                                            |
//
// The cells compare the incoming key in the accept cycle, the match encoder
// resolves position and value in the next, and the table update plus result
// load happen in the apply state once the result register is free.
// Reset clears the entry count and control; cell contents stay undefined and
// are never read at or above the count, so no clearing pass is needed.
// A new item is taken while an earlier result still waits on m_axis; the
// update cycle holds until the result register is free.
`default_nettype none

module key_value_table_compacting #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire                                                  clk_i,
  input  wire                                                  rst_ni,
  // key, then value_in, from bit 0 up; zero padded to whole bytes
  input  wire  [((kvtc_pkg::KEY_W + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // kind
  input  wire  [kvtc_pkg::KIND_W-1:0]                           s_axis_tuser,
  input  wire                                                  s_axis_tvalid,
  output logic                                                 s_axis_tready,
  // found, position, value_out, entry_count, table_full, from bit 0 up
  output logic [((2 + $clog2(CAPACITY) + VALUE_BITS + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                                                               m_axis_tdata,
  output logic                                                 m_axis_tvalid,
  input  wire                                                  m_axis_tready
);
  import kvtc_pkg::*;

  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_BITS = 2 + POS_W + VALUE_BITS + CNT_W;
  localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_RESOLVE = 3'b010,
    S_APPLY   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Operation held from accept through update.
  kind_e                 op_kind_q;
  logic [KEY_W-1:0]      op_key_q;
  logic [VALUE_BITS-1:0] op_value_q;

  logic [CNT_W-1:0]      count_q, count_d;

  // Resolved match.
  logic                  hit_q;
  logic [POS_W-1:0]      hit_pos_q;
  logic [VALUE_BITS-1:0] hit_value_q;
  logic                  hit_d;
  logic [POS_W-1:0]      hit_pos_d;
  logic [VALUE_BITS-1:0] hit_value_d;

  // Result register.
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [POS_W-1:0]      out_pos_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [CNT_W-1:0]      out_count_q;
  logic                  out_full_q;

  // Result of the update cycle.
  logic                  res_found;
  logic [POS_W-1:0]      res_pos;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_full;
  logic                  do_add;
  logic                  do_del;

  logic                  s_acc;
  logic                  out_free;
  logic                  apply_go;

  // Cell row.
  cell_ctrl_t                           cell_ctrl [CAPACITY];
  logic [CAPACITY-1:0][KEY_W-1:0]       cell_key;
  logic [CAPACITY-1:0][VALUE_BITS-1:0]  cell_value;
  logic [CAPACITY-1:0]                  cell_match;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign apply_go      = (state_q == S_APPLY) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (s_acc) state_d = S_RESOLVE;
      S_RESOLVE: state_d = S_APPLY;
      S_APPLY:   if (apply_go) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the operation on accept; the cells compare the same key this cycle.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_kind_q  <= kind_e'(s_axis_tuser);
      op_key_q   <= s_axis_tdata[KEY_W-1:0];
      op_value_q <= s_axis_tdata[KEY_W +: VALUE_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Cells: compare in parallel, load at the tail, shift down above a delete
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]      nbr_key;
    logic [VALUE_BITS-1:0] nbr_value;

    if (i == CAPACITY - 1) begin : g_top
      // The top cell has no upper neighbor; its stale copy lies above the count.
      assign nbr_key   = cell_key[i];
      assign nbr_value = cell_value[i];
    end else begin : g_mid
      assign nbr_key   = cell_key[i+1];
      assign nbr_value = cell_value[i+1];
    end

    assign cell_ctrl[i].cmp   = s_acc;
    assign cell_ctrl[i].load  = apply_go && do_add && (count_q == CNT_W'(i));
    assign cell_ctrl[i].shift = apply_go && do_del && (POS_W'(i) >= hit_pos_q);

    kvtc_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[i]),
      .valid_i      (CNT_W'(i) < count_q),
      .search_key_i (s_axis_tdata[KEY_W-1:0]),
      .new_key_i    (op_key_q),
      .new_value_i  (op_value_q),
      .nbr_key_i    (nbr_key),
      .nbr_value_i  (nbr_value),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .match_o      (cell_match[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Resolve: encode the match vector and hold it for the update cycle
  // ---------------------------------------------------------------------------
  kvtc_match_enc #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_match_enc (
    .match_i (cell_match),
    .value_i (cell_value),
    .hit_o   (hit_d),
    .pos_o   (hit_pos_d),
    .value_o (hit_value_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (state_q == S_RESOLVE) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESOLVE) begin
      hit_pos_q   <= hit_pos_d;
      hit_value_q <= hit_value_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Update: decide the table change and the result fields
  // ---------------------------------------------------------------------------
  always_comb begin
    res_found = hit_q;
    res_pos   = hit_q ? hit_pos_q : '0;
    res_value = '0;
    res_full  = 1'b0;
    do_add    = 1'b0;
    do_del    = 1'b0;
    count_d   = count_q;
    case (op_kind_q)
      KIND_ADD: begin
        // Existing key: report its place, leave the stored value alone.
        if (!hit_q) begin
          if (count_q == CNT_W'(CAPACITY)) begin
            res_full = 1'b1;
          end else begin
            do_add  = 1'b1;
            res_pos = count_q[POS_W-1:0];
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      KIND_DELETE: begin
        if (hit_q) begin
          res_value = hit_value_q;
          do_del    = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
      end
      default: begin
        // Lookup, and the unused code that acts as one.
        if (hit_q) begin
          res_value = hit_value_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (apply_go) begin
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold until taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      out_found_q <= res_found;
      out_pos_q   <= res_pos;
      out_value_q <= res_value;
      out_count_q <= count_d;
      out_full_q  <= res_full;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'({out_full_q, out_count_q, out_value_q, out_pos_q, out_found_q});

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Keys are unique, so no two cells may match at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cell_match))
    else $error("more than one cell matched the key");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The count only moves in the update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !apply_go |=> $stable(count_q))
    else $error("entry count changed outside an update");

  // A rejected add is only reported for a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_full_q) |-> (out_count_q == CNT_W'(CAPACITY)))
    else $error("table_full reported with free entries");

  // Add and delete are never decided together, so no cell gets a load and a shift at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(do_add && do_del))
    else $error("add and delete decided together");

endmodule

`default_nettype wire
